FILE: rtl/hvsp_pkg.sv
// Shared types and constants for the high-voltage serial programming read sequencer.
// No dependencies; every other file uses it by scoped names.
package hvsp_pkg;

    // Request kinds, latched at start
    localparam logic MODE_SIG  = 1'b0;
    localparam logic MODE_FUSE = 1'b1;

    // Fixed frame bytes (SDI data / SII instruction)
    localparam logic [7:0] SIG_SEL_DATA   = 8'h08;
    localparam logic [7:0] FUSE_SEL_DATA  = 8'h04;
    localparam logic [7:0] INST_LOAD_CMD  = 8'h4C;
    localparam logic [7:0] INST_LOAD_ADDR = 8'h0C;
    localparam logic [7:0] INST_RD_SIG_LO = 8'h68;
    localparam logic [7:0] INST_RD_SIG_HI = 8'h6C;

    // Frame geometry
    localparam logic [1:0] SIG_LAST_FRAME  = 2'd3;
    localparam logic [1:0] FUSE_LAST_FRAME = 2'd2;
    localparam logic [3:0] FRAME_LAST_POS  = 4'd10;
    localparam logic [3:0] DATA_LAST_POS   = 4'd8;

    typedef struct packed {
        logic       sdo_level;
        logic [7:0] fuse_inst_b;
        logic [7:0] fuse_inst_a;
        logic [7:0] sig_address;
        logic       func;
        logic       start_req;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_value;
        logic       done_res;
        logic       busy_res;
        logic       sii_level;
        logic       sdi_level;
        logic       clock_pulse;
    } res_t;

    localparam int IN_W  = $bits(in_item_t);
    localparam int RES_W = $bits(res_t);

endpackage

FILE: rtl/hvsp_stage.sv
// Pipeline register slice with valid/ready flow control.
// Depends on hvsp_pkg for the default width.
module hvsp_stage #(
    parameter int W = hvsp_pkg::IN_W
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         up_valid,
    output logic         up_ready,
    input  logic [W-1:0] up_data,
    output logic         dn_valid,
    input  logic         dn_ready,
    output logic [W-1:0] dn_data
);

    logic         valid_reg;
    logic [W-1:0] data_reg;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= up_data;
        end
    end

endmodule

FILE: rtl/hvsp_step.sv
// Sequencer state and per-period frame logic: one serial clock period per transfer.
// Depends on hvsp_pkg for item types and frame constants.
module hvsp_step (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  hvsp_pkg::in_item_t item,
    output hvsp_pkg::res_t    res
);

    logic       active_reg, active_next;
    logic       mode_reg, mode_next;
    logic [7:0] addr_reg, addr_next;
    logic [7:0] inst_a_reg, inst_a_next;
    logic [7:0] inst_b_reg, inst_b_next;
    logic [1:0] frame_reg, frame_next;
    logic [3:0] pos_reg, pos_next;
    logic [7:0] shift_reg, shift_next;

    logic       run;
    logic       mode_e;
    logic [7:0] addr_e, inst_a_e, inst_b_e;
    logic [1:0] frame_e;
    logic [3:0] pos_e;
    logic [7:0] shift_e;
    logic [7:0] data_b, inst_b;
    logic [2:0] bit_sel;
    logic       in_data;
    logic       frame_end;
    logic       done;
    logic [1:0] last_frame;

    // A start while idle uses the fresh operands in the same period
    assign run      = active_reg || item.start_req;
    assign mode_e   = active_reg ? mode_reg   : item.func;
    assign addr_e   = active_reg ? addr_reg   : item.sig_address;
    assign inst_a_e = active_reg ? inst_a_reg : item.fuse_inst_a;
    assign inst_b_e = active_reg ? inst_b_reg : item.fuse_inst_b;
    assign frame_e  = active_reg ? frame_reg  : 2'd0;
    assign pos_e    = active_reg ? pos_reg    : 4'd0;
    assign shift_e  = active_reg ? shift_reg  : 8'd0;

    always_comb
    begin
        data_b = 8'd0;
        inst_b = 8'd0;
        if (mode_e == hvsp_pkg::MODE_SIG)
        begin
            case (frame_e)
                2'd0:
                begin
                    data_b = hvsp_pkg::SIG_SEL_DATA;
                    inst_b = hvsp_pkg::INST_LOAD_CMD;
                end
                2'd1:
                begin
                    data_b = addr_e;
                    inst_b = hvsp_pkg::INST_LOAD_ADDR;
                end
                2'd2:    inst_b = hvsp_pkg::INST_RD_SIG_LO;
                default: inst_b = hvsp_pkg::INST_RD_SIG_HI;
            endcase
        end
        else
        begin
            case (frame_e)
                2'd0:
                begin
                    data_b = hvsp_pkg::FUSE_SEL_DATA;
                    inst_b = hvsp_pkg::INST_LOAD_CMD;
                end
                2'd1:    inst_b = inst_a_e;
                2'd2:    inst_b = inst_b_e;
                default: inst_b = 8'd0;
            endcase
        end
    end

    // positions 1..8 carry bits 7..0
    assign in_data    = (pos_e != 4'd0) && (pos_e <= hvsp_pkg::DATA_LAST_POS);
    assign bit_sel    = 3'(hvsp_pkg::DATA_LAST_POS - pos_e);
    assign last_frame = (mode_e == hvsp_pkg::MODE_SIG) ? hvsp_pkg::SIG_LAST_FRAME
                                                       : hvsp_pkg::FUSE_LAST_FRAME;
    assign frame_end  = pos_e >= hvsp_pkg::FRAME_LAST_POS;
    assign done       = run && frame_end && (frame_e >= last_frame);

    always_comb
    begin
        if (pos_e == 4'd0)
            shift_next = 8'd0;
        else if (in_data)
            shift_next = {shift_e[6:0], item.sdo_level};
        else
            shift_next = shift_e;
    end

    always_comb
    begin
        res             = '0;
        res.clock_pulse = run;
        res.busy_res    = run;
        res.sdi_level   = run && in_data && data_b[bit_sel];
        res.sii_level   = run && in_data && inst_b[bit_sel];
        res.done_res    = done;
        res.read_value  = done ? shift_next : 8'd0;
    end

    always_comb
    begin
        active_next = active_reg;
        mode_next   = mode_reg;
        addr_next   = addr_reg;
        inst_a_next = inst_a_reg;
        inst_b_next = inst_b_reg;
        frame_next  = frame_reg;
        pos_next    = pos_reg;
        if (fire && run)
        begin
            active_next = !done;
            mode_next   = mode_e;
            addr_next   = addr_e;
            inst_a_next = inst_a_e;
            inst_b_next = inst_b_e;
            if (frame_end)
            begin
                pos_next   = 4'd0;
                frame_next = done ? 2'd0 : frame_e + 2'd1;
            end
            else
            begin
                pos_next   = pos_e + 4'd1;
                frame_next = frame_e;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            mode_reg   <= 1'b0;
            addr_reg   <= 8'd0;
            inst_a_reg <= 8'd0;
            inst_b_reg <= 8'd0;
            frame_reg  <= 2'd0;
            pos_reg    <= 4'd0;
            shift_reg  <= 8'd0;
        end
        else
        begin
            active_reg <= active_next;
            mode_reg   <= mode_next;
            addr_reg   <= addr_next;
            inst_a_reg <= inst_a_next;
            inst_b_reg <= inst_b_next;
            frame_reg  <= frame_next;
            pos_reg    <= pos_next;
            if (fire && run)
                shift_reg <= shift_next;
        end
    end

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res.done_res |-> res.busy_res)
        else $error("done without busy");

    a_value_done: assert property (@(posedge clk) disable iff (!rst_n)
        (res.read_value != 8'd0) |-> res.done_res)
        else $error("read value outside done period");

    a_stay_active: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && active_reg && (pos_reg != hvsp_pkg::FRAME_LAST_POS)) |=> active_reg)
        else $error("request ended mid-frame");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= hvsp_pkg::FRAME_LAST_POS)
        else $error("bit position out of range");

endmodule

FILE: rtl/hvsp_read_sequencer.sv
// Top level of the high-voltage serial programming read sequencer.
// Depends on hvsp_pkg, hvsp_stage and hvsp_step.
//
// Each input transfer is one serial clock period of a high-voltage serial
// programming read. An idle block starts a request on a transfer with
// start_req set: a signature read (s_tuser 0, four frames) or a fuse read
// (s_tuser 1, three frames). Each frame is 11 periods: a zero bit, eight bits
// sent MSB first on SDI and SII, then two zero bits; the target SDO level is
// shifted in at positions 1 to 8. Every input transfer yields exactly one
// output transfer; m_tlast marks the final period of a request, whose
// read_value carries the byte gathered in the last frame. Operands are
// latched at start; start requests while busy are ignored. The path is an
// input register slice, the frame logic, and an output register slice, and
// one transfer is taken every cycle when the output side keeps up.
// Backpressure on m_tready propagates to s_tready.
module hvsp_read_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [0] start_req, [8:1] sig_address, [16:9] fuse_inst_a,
    // [24:17] fuse_inst_b, [25] sdo_level, [31:26] zero
    input  logic [31:0] s_tdata,
    // [0] func (0 signature, 1 fuse)
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] clock_pulse, [1] sdi_level, [2] sii_level, [3] busy_res,
    // [11:4] read_value, [15:12] zero
    output logic [15:0] m_tdata,
    // done_res
    output logic        m_tlast
);

    hvsp_pkg::in_item_t in_item, stage_item;
    hvsp_pkg::res_t     res, out_res;
    logic [hvsp_pkg::IN_W-1:0]  stage_bits;
    logic [hvsp_pkg::RES_W-1:0] out_bits;
    logic                       mid_valid;
    logic                       mid_ready;

    always_comb
    begin
        in_item             = '0;
        in_item.start_req   = s_tdata[0];
        in_item.func        = s_tuser;
        in_item.sig_address = s_tdata[8:1];
        in_item.fuse_inst_a = s_tdata[16:9];
        in_item.fuse_inst_b = s_tdata[24:17];
        in_item.sdo_level   = s_tdata[25];
    end

    // input register slice
    hvsp_stage #(.W(hvsp_pkg::IN_W)) u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s_tvalid),
        .up_ready (s_tready),
        .up_data  (in_item),
        .dn_valid (mid_valid),
        .dn_ready (mid_ready),
        .dn_data  (stage_bits)
    );

    assign stage_item = hvsp_pkg::in_item_t'(stage_bits);

    // state advances only when the period moves into the output slice
    hvsp_step u_step (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (mid_valid && mid_ready),
        .item  (stage_item),
        .res   (res)
    );

    // output register slice
    hvsp_stage #(.W(hvsp_pkg::RES_W)) u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (mid_valid),
        .up_ready (mid_ready),
        .up_data  (res),
        .dn_valid (m_tvalid),
        .dn_ready (m_tready),
        .dn_data  (out_bits)
    );

    assign out_res = hvsp_pkg::res_t'(out_bits);
    assign m_tdata = {4'd0, out_res.read_value, out_res.busy_res, out_res.sii_level,
                      out_res.sdi_level, out_res.clock_pulse};
    assign m_tlast = out_res.done_res;

endmodule
